[design/sat_pkg.sv]
// ----------------------------------------------------------------------------
// sat_pkg
// Shared types, codes and constants of the session affinity table.
// ----------------------------------------------------------------------------
package sat_pkg;

  localparam int ENTRIES   = 64;
  localparam int KEY_BYTES = 32;
  localparam int KEY_W     = 256;
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W     = $clog2(ENTRIES + 1);

  localparam logic [1:0] MODE_LOOKUP  = 2'd0;
  localparam logic [1:0] MODE_WRITE   = 2'd1;
  localparam logic [1:0] MODE_RESTORE = 2'd2;

  localparam logic [2:0] KIND_MISS = 3'd0;
  localparam logic [2:0] KIND_HIT  = 3'd1;
  localparam logic [2:0] KIND_ADD  = 3'd2;
  localparam logic [2:0] KIND_UPD  = 3'd3;
  localparam logic [2:0] KIND_DEL  = 3'd4;

  localparam logic [6:0] MAX_ENTRIES_RESET = 7'd64;

  function automatic logic [KEY_W-1:0] key_mask();
    logic [KEY_W-1:0] m;
    m = '0;
    for (int b = 0; b < KEY_W / 8; b++) begin
      if (b < KEY_BYTES) m[8*b +: 8] = 8'hff;
    end
    return m;
  endfunction

  localparam logic [KEY_W-1:0] KEY_MASK = key_mask();

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] key_word0;
    logic [63:0] key_word1;
    logic [63:0] key_word2;
    logic [63:0] key_word3;
    logic [31:0] server_addr;
    logic [15:0] server_port;
    logic [31:0] cur_time;
  } req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] out_key_word0;
    logic [63:0] out_key_word1;
    logic [63:0] out_key_word2;
    logic [63:0] out_key_word3;
    logic [31:0] out_addr;
    logic [15:0] out_port;
    logic [31:0] out_time;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [31:0]      addr;
    logic [15:0]      port;
    logic [31:0]      tstamp;
    logic [31:0]      order;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic wr;
  } cell_ctl_t;

endpackage

[design/sat_cell.sv]
// ----------------------------------------------------------------------------
// sat_cell
// One table entry of the rotating ring; takes its neighbour's entry on shift.
// ----------------------------------------------------------------------------
module sat_cell (
  input  logic               clk,
  input  logic               rst,
  input  sat_pkg::cell_ctl_t ctl,
  input  sat_pkg::entry_t    prev,
  input  sat_pkg::entry_t    wdata,
  output sat_pkg::entry_t    ent
);

  sat_pkg::entry_t ent_q;
  logic            vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (ctl.wr) begin
      vld <= wdata.valid;
    end else if (ctl.shift) begin
      vld <= prev.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      ent_q <= wdata;
    end else if (ctl.shift) begin
      ent_q <= prev;
    end
  end

  always_comb begin
    ent       = ent_q;
    ent.valid = vld;
  end

endmodule

[design/session_affinity_table_lru_top.sv]
// ----------------------------------------------------------------------------
// session_affinity_table_lru_top
// Session key to server endpoint table with oldest-time eviction.
// ----------------------------------------------------------------------------
// Each transaction is accepted, then the ring of entry cells rotates once past
// the compare head, and then the write is applied; the first result, if any,
// follows. Results then leave one per cycle as the output side takes them,
// and the next request is accepted once the last result has gone. Register
// writes are taken only while the block is idle.
module session_affinity_table_lru_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  sat_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output sat_pkg::rsp_t rsp,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [6:0]    cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_APPLY = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [6:0]                 max_entries;
  logic [sat_pkg::CNT_W-1:0]  entry_count;
  logic [31:0]                write_sequence;
  logic [sat_pkg::IDX_W-1:0]  step;

  logic [1:0]                 mode;
  logic [sat_pkg::KEY_W-1:0]  key;
  logic [31:0]                in_addr;
  logic [15:0]                in_port;
  logic [31:0]                in_time;

  logic                       match_hit, best_hit;
  logic [sat_pkg::IDX_W-1:0]  match_pos, free_pos, best_pos;
  logic [31:0]                match_addr;
  logic [15:0]                match_port;
  logic [31:0]                best_time, best_age;
  logic [sat_pkg::KEY_W-1:0]  best_key;

  logic                       pending;
  sat_pkg::rsp_t              rsp_q, rec2;

  sat_pkg::entry_t            ent [sat_pkg::ENTRIES];
  sat_pkg::entry_t            head, wdata;
  logic                       wr_any;
  logic [sat_pkg::IDX_W-1:0]  wr_pos;
  logic [sat_pkg::IDX_W-1:0]  head_pos;
  logic [31:0]                cand_age;
  logic                       cand_older;
  logic [sat_pkg::CNT_W-1:0]  lim;
  logic [1:0]                 n_rec;
  sat_pkg::rsp_t              rec1_c, rec2_c;
  logic [sat_pkg::CNT_W-1:0]  count_next;
  logic                       seq_inc;

  assign req_stall = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign rsp_valid = (state == S_OUT);
  assign rsp       = rsp_q;

  // ring of entry cells; the last cell feeds the first
  for (genvar i = 0; i < sat_pkg::ENTRIES; i++) begin : g_cell
    sat_pkg::cell_ctl_t ctl;
    assign ctl.shift = (state == S_SCAN);
    assign ctl.wr    = wr_any && (wr_pos == sat_pkg::IDX_W'(i));
    if (i == 0) begin : g_first
      sat_cell u_cell (.clk, .rst, .ctl, .prev(ent[sat_pkg::ENTRIES-1]), .wdata,
                       .ent(ent[i]));
    end else begin : g_next
      sat_cell u_cell (.clk, .rst, .ctl, .prev(ent[i-1]), .wdata, .ent(ent[i]));
    end
  end

  assign head       = ent[sat_pkg::ENTRIES-1];
  assign head_pos   = sat_pkg::IDX_W'(sat_pkg::ENTRIES - 1) - step;
  assign cand_age   = write_sequence - head.order;
  assign cand_older = !best_hit || (head.tstamp < best_time) ||
                      ((head.tstamp == best_time) && (cand_age > best_age));

  always_comb begin
    if (32'(max_entries) > 32'(sat_pkg::ENTRIES)) begin
      lim = sat_pkg::CNT_W'(sat_pkg::ENTRIES);
    end else begin
      lim = sat_pkg::CNT_W'(max_entries);
    end
  end

  // decide the single cell write and the records of this transaction
  always_comb begin
    wr_any       = 1'b0;
    wr_pos       = match_pos;
    wdata.valid  = 1'b1;
    wdata.key    = key;
    wdata.addr   = in_addr;
    wdata.port   = in_port;
    wdata.tstamp = in_time;
    wdata.order  = write_sequence;
    n_rec        = 2'd0;
    count_next   = entry_count;
    seq_inc      = 1'b0;

    rec1_c = '{kind: sat_pkg::KIND_ADD, out_key_word0: key[63:0],
               out_key_word1: key[127:64], out_key_word2: key[191:128],
               out_key_word3: key[255:192], out_addr: in_addr, out_port: in_port,
               out_time: in_time, last: 1'b1};
    rec2_c = rec1_c;

    if (state == S_APPLY) begin
      unique case (mode)
        sat_pkg::MODE_LOOKUP: begin
          n_rec = 2'd1;
          rec1_c.out_time = '0;
          if (match_hit) begin
            rec1_c.kind     = sat_pkg::KIND_HIT;
            rec1_c.out_addr = match_addr;
            rec1_c.out_port = match_port;
          end else begin
            rec1_c.kind     = sat_pkg::KIND_MISS;
            rec1_c.out_addr = '0;
            rec1_c.out_port = '0;
          end
        end
        sat_pkg::MODE_WRITE: begin
          if (lim != '0) begin
            seq_inc = 1'b1;
            wr_any  = 1'b1;
            n_rec   = 2'd1;
            if (match_hit) begin
              rec1_c.kind = sat_pkg::KIND_UPD;
            end else if (entry_count >= lim) begin
              // evict the oldest and reuse its cell for the new key
              wr_pos = best_pos;
              n_rec  = 2'd2;
              rec1_c = '{kind: sat_pkg::KIND_DEL, out_key_word0: best_key[63:0],
                         out_key_word1: best_key[127:64],
                         out_key_word2: best_key[191:128],
                         out_key_word3: best_key[255:192], out_addr: '0,
                         out_port: '0, out_time: '0, last: 1'b0};
            end else begin
              wr_pos     = free_pos;
              count_next = entry_count + 1'b1;
            end
          end
        end
        sat_pkg::MODE_RESTORE: begin
          if (match_hit) begin
            seq_inc = 1'b1;
            wr_any  = 1'b1;
          end else if (entry_count < lim) begin
            seq_inc    = 1'b1;
            wr_any     = 1'b1;
            wr_pos     = free_pos;
            count_next = entry_count + 1'b1;
          end
        end
        default: begin
          n_rec = 2'd0;
        end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (req_valid) state_next = S_SCAN;
      S_SCAN:  if (step == sat_pkg::IDX_W'(sat_pkg::ENTRIES - 1)) state_next = S_APPLY;
      S_APPLY: state_next = (n_rec == 2'd0) ? S_IDLE : S_OUT;
      S_OUT:   if (!rsp_stall && !pending) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      max_entries    <= sat_pkg::MAX_ENTRIES_RESET;
      entry_count    <= '0;
      write_sequence <= '0;
      step           <= '0;
      pending        <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) max_entries <= cfg_data;
      if (state == S_IDLE) step <= '0;
      else if (state == S_SCAN) step <= step + 1'b1;
      if (state == S_APPLY) begin
        entry_count <= count_next;
        if (seq_inc) write_sequence <= write_sequence + 32'd1;
        pending <= (n_rec == 2'd2);
      end else if (state == S_OUT && !rsp_stall) begin
        pending <= 1'b0;
      end
    end
  end

  // transaction capture, scan results and output records
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      mode      <= req.mode;
      key       <= {req.key_word3, req.key_word2, req.key_word1, req.key_word0}
                   & sat_pkg::KEY_MASK;
      in_addr   <= req.server_addr;
      in_port   <= req.server_port;
      in_time   <= req.cur_time;
      match_hit <= 1'b0;
      best_hit  <= 1'b0;
    end
    if (state == S_SCAN) begin
      if (head.valid && head.key == key) begin
        match_hit  <= 1'b1;
        match_pos  <= head_pos;
        match_addr <= head.addr;
        match_port <= head.port;
      end
      if (!head.valid) begin
        free_pos <= head_pos;
      end
      if (head.valid && cand_older) begin
        best_hit  <= 1'b1;
        best_pos  <= head_pos;
        best_time <= head.tstamp;
        best_age  <= cand_age;
        best_key  <= head.key;
      end
    end
    if (state == S_APPLY) begin
      rsp_q <= rec1_c;
      rec2  <= rec2_c;
    end else if (state == S_OUT && !rsp_stall && pending) begin
      rsp_q <= rec2;
    end
  end

endmodule

[design/sat_checker.sv]
// ----------------------------------------------------------------------------
// sat_checker
// Port-level checks of the session affinity table, bound to the top level.
// ----------------------------------------------------------------------------
module sat_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input sat_pkg::rsp_t rsp
);

  // a waiting result holds until taken
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // no new request while a result is still pending
  a_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> req_stall)
    else $error("request accepted with result pending");

  // an eviction record is never the final one
  a_del_not_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.kind == sat_pkg::KIND_DEL |-> !rsp.last)
    else $error("eviction marked last");

  // an eviction is followed straight away by its add record
  a_del_then_add: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_stall && rsp.kind == sat_pkg::KIND_DEL
    |=> rsp_valid && rsp.kind == sat_pkg::KIND_ADD && rsp.last)
    else $error("eviction not followed by add");

  // the scan takes time: no result right after a request is taken
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> !rsp_valid)
    else $error("result too early");

endmodule

bind session_affinity_table_lru_top sat_checker u_sat_checker (
  .clk, .rst, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .rsp
);
